// ===== hdl/prbuf_pkg.sv =====
// package: sizes, word types, datapath commands and status for the bond union-find block
`timescale 1ns / 1ps
package prbuf_pkg;

  localparam int NODES     = 1024;
  localparam int MAX_GROUP = 64;

  localparam int ADDR_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES) + 1;
  localparam int PROD_W = 2 * CNT_W - 1;
  localparam int SLOT_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int SCNT_W = $clog2(MAX_GROUP + 1);

  localparam int END_W = 10;
  localparam int POS_W = 6;
  localparam int SIZE_W = 11;

  typedef struct packed {
    logic [END_W-1:0] end_a;
    logic [END_W-1:0] end_b;
    logic             last_candidate;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  chosen_position;
    logic              merged;
    logic [END_W-1:0]  new_root;
    logic [SIZE_W-1:0] joined_size;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_READ_PARENT,
    OP_STEP,
    OP_SET_ROOT,
    OP_COMP_WRITE,
    OP_START_B,
    OP_READ_CNT_A,
    OP_READ_CNT_B,
    OP_MUL,
    OP_UPDATE,
    OP_MRD_A,
    OP_MRD_B,
    OP_MLATCH,
    OP_MERGE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_b;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic at_root;
    logic cur_is_root;
    logic last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hdl/product_rule_bond_union_find.sv =====
// top level: product-rule bond selection over a union-find forest
//
// input channel: one word per candidate bond (end_a, end_b, last_candidate).
// output channel: one word per group, sent after the candidate marked last:
// winning position, merged flag, new root and joined cluster size.
// after reset the parent and size stores are swept over all 1024 nodes,
// one node a cycle; in_ready_o stays low until the sweep is done.
// a new candidate is accepted only when the previous one is done: each
// find walks the chain to its root, one parent read per hop, then
// rewrites every node below the root on the path to point at the root
// (path compression), all through the single read port of the parent store.
// a last candidate then runs the merge steps (two size reads, a latch and
// the merge itself), and its word is valid the cycle after the merge.
// the result sits in an output register: the next candidate is accepted
// while it waits, and only the next merge stalls until the receiver takes it.
`timescale 1ns / 1ps
module product_rule_bond_union_find import prbuf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  prbuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prbuf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/prbuf_ram.sv =====
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps
module prbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/prbuf_dp.sv =====
// datapath: parent and size stores, find walk registers, best-candidate tracking, output word
`timescale 1ns / 1ps
module prbuf_dp import prbuf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_data_o
);

  logic [ADDR_W-1:0] clr_q;
  logic [SCNT_W-1:0] slot_cnt_q;
  logic              out_valid_q;

  logic [ADDR_W-1:0] cur_q, start_q, end_b_q, root_a_q, root_b_q;
  logic [ADDR_W-1:0] best_a_q, best_b_q;
  logic [SLOT_W-1:0] best_slot_q;
  logic [PROD_W-1:0] best_prod_q, product_q;
  logic [CNT_W-1:0]  cnt_a_q, cnt_b_q;
  logic              last_q;
  out_word_t         out_q;

  logic              p_we, p_re, c_we, c_re;
  logic [ADDR_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic [ADDR_W-1:0] c_waddr, c_raddr;
  logic [CNT_W-1:0]  c_wdata, c_rdata;

  logic [ADDR_W-1:0]    root_sel;
  logic [PROD_W-1:0]    prod_full;
  logic                 a_wins, distinct;
  logic [ADDR_W-1:0]    win_root, child;
  logic [CNT_W-1:0]     sum, size;

  assign root_sel  = cmd_i.sel_b ? root_b_q : root_a_q;
  assign prod_full = PROD_W'(cnt_a_q) * PROD_W'(c_rdata);
  assign a_wins    = cnt_a_q >= cnt_b_q;
  assign distinct  = best_a_q != best_b_q;
  assign win_root  = a_wins ? best_a_q : best_b_q;
  assign child     = a_wins ? best_b_q : best_a_q;
  assign sum       = cnt_a_q + cnt_b_q;
  assign size      = distinct ? sum : cnt_a_q;

  always_comb begin
    p_we    = 1'b0;
    p_waddr = cur_q;
    p_wdata = root_sel;
    p_re    = 1'b0;
    p_raddr = cur_q;
    c_we    = 1'b0;
    c_waddr = win_root;
    c_wdata = sum;
    c_re    = 1'b0;
    c_raddr = root_a_q;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        c_we    = 1'b1;
        c_waddr = clr_q;
        c_wdata = CNT_W'(1);
      end
      OP_READ_PARENT: p_re = 1'b1;
      OP_COMP_WRITE:  p_we = 1'b1;
      OP_READ_CNT_A: begin
        c_re    = 1'b1;
        c_raddr = root_a_q;
      end
      OP_READ_CNT_B: begin
        c_re    = 1'b1;
        c_raddr = root_b_q;
      end
      OP_MRD_A: begin
        c_re    = 1'b1;
        c_raddr = best_a_q;
      end
      OP_MRD_B: begin
        c_re    = 1'b1;
        c_raddr = best_b_q;
      end
      OP_MERGE: begin
        c_we    = distinct;
        p_we    = distinct;
        p_waddr = child;
        p_wdata = win_root;
      end
      default: ;
    endcase
  end

  prbuf_ram #(.WIDTH(ADDR_W), .DEPTH(NODES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  prbuf_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      slot_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.op == OP_UPDATE && slot_cnt_q < SCNT_W'(MAX_GROUP)) begin
        slot_cnt_q <= slot_cnt_q + SCNT_W'(1);
      end
      if (cmd_i.op == OP_MERGE) begin
        slot_cnt_q  <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        cur_q   <= in_data_i.end_a[ADDR_W-1:0];
        start_q <= in_data_i.end_a[ADDR_W-1:0];
        end_b_q <= in_data_i.end_b[ADDR_W-1:0];
        last_q  <= in_data_i.last_candidate;
      end
      OP_STEP:       cur_q <= p_rdata;
      OP_COMP_WRITE: cur_q <= p_rdata;
      OP_SET_ROOT: begin
        if (cmd_i.sel_b) begin
          root_b_q <= cur_q;
        end else begin
          root_a_q <= cur_q;
        end
        cur_q <= start_q;
      end
      OP_START_B: begin
        cur_q   <= end_b_q;
        start_q <= end_b_q;
      end
      OP_READ_CNT_B: cnt_a_q <= c_rdata;
      OP_MUL:        product_q <= prod_full;
      OP_UPDATE: begin
        if (slot_cnt_q < SCNT_W'(MAX_GROUP) &&
            (slot_cnt_q == '0 || product_q < best_prod_q)) begin
          best_prod_q <= product_q;
          best_a_q    <= root_a_q;
          best_b_q    <= root_b_q;
          best_slot_q <= slot_cnt_q[SLOT_W-1:0];
        end
      end
      OP_MRD_B:  cnt_a_q <= c_rdata;
      OP_MLATCH: cnt_b_q <= c_rdata;
      OP_MERGE: begin
        out_q.chosen_position <= POS_W'(best_slot_q);
        out_q.merged          <= distinct;
        out_q.new_root        <= END_W'(distinct ? win_root : best_a_q);
        out_q.joined_size     <= SIZE_W'(size);
      end
      default: ;
    endcase
  end

  assign status_o.clear_last  = clr_q == ADDR_W'(NODES - 1);
  assign status_o.at_root     = p_rdata == cur_q;
  assign status_o.cur_is_root = cur_q == root_sel;
  assign status_o.last        = last_q;
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/prbuf_ctrl.sv =====
// controller: sequences clearing, the two finds with path compression, selection and merge
`timescale 1ns / 1ps
module prbuf_ctrl import prbuf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_WALK,
    S_CRD,
    S_CWR,
    S_CNT_A,
    S_CNT_B,
    S_MUL,
    S_BEST,
    S_MA,
    S_MB,
    S_MLAT,
    S_MERGE
  } state_e;

  state_e state_q;
  logic   sel_b_q;
  logic   in_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      sel_b_q    <= 1'b0;
      in_ready_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (status_i.clear_last) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            in_ready_q <= 1'b0;
            sel_b_q    <= 1'b0;
            state_q    <= S_RD;
          end
        end
        S_RD:   state_q <= S_WALK;
        S_WALK: state_q <= status_i.at_root ? S_CRD : S_RD;
        S_CRD: begin
          if (!status_i.cur_is_root) begin
            state_q <= S_CWR;
          end else if (sel_b_q) begin
            state_q <= S_CNT_A;
          end else begin
            sel_b_q <= 1'b1;
            state_q <= S_RD;
          end
        end
        S_CWR:   state_q <= S_CRD;
        S_CNT_A: state_q <= S_CNT_B;
        S_CNT_B: state_q <= S_MUL;
        S_MUL:   state_q <= S_BEST;
        S_BEST: begin
          if (status_i.last) begin
            state_q <= S_MA;
          end else begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        S_MA:   state_q <= S_MB;
        S_MB:   state_q <= S_MLAT;
        S_MLAT: state_q <= S_MERGE;
        S_MERGE: begin
          if (!status_i.out_busy) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd_o.sel_b = sel_b_q;
    unique case (state_q)
      S_CLEAR: cmd_o.op = OP_CLEAR;
      S_IDLE:  cmd_o.op = in_valid_i ? OP_CAPTURE : OP_NONE;
      S_RD:    cmd_o.op = OP_READ_PARENT;
      S_WALK:  cmd_o.op = status_i.at_root ? OP_SET_ROOT : OP_STEP;
      S_CRD: begin
        if (!status_i.cur_is_root) begin
          cmd_o.op = OP_READ_PARENT;
        end else begin
          cmd_o.op = sel_b_q ? OP_NONE : OP_START_B;
        end
      end
      S_CWR:   cmd_o.op = OP_COMP_WRITE;
      S_CNT_A: cmd_o.op = OP_READ_CNT_A;
      S_CNT_B: cmd_o.op = OP_READ_CNT_B;
      S_MUL:   cmd_o.op = OP_MUL;
      S_BEST:  cmd_o.op = OP_UPDATE;
      S_MA:    cmd_o.op = OP_MRD_A;
      S_MB:    cmd_o.op = OP_MRD_B;
      S_MLAT:  cmd_o.op = OP_MLATCH;
      S_MERGE: cmd_o.op = status_i.out_busy ? OP_NONE : OP_MERGE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o = in_ready_q;

endmodule

// ===== hdl/prbuf_chk.sv =====
// checker: port-level properties of the bond union-find block, bound to the top level
`timescale 1ns / 1ps
module prbuf_chk import prbuf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // one candidate at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a word while busy");

  // a non-last candidate with an empty output slot does not produce a word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.last_candidate && !out_valid_o
    |=> !out_valid_o)
    else $error("word produced without a last candidate");

  // a join covers at least two nodes
  a_join_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.merged |-> out_data_o.joined_size > SIZE_W'(1))
    else $error("merged cluster smaller than two");

  // any cluster holds at least one node
  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.joined_size != '0)
    else $error("zero cluster size reported");

endmodule

bind product_rule_bond_union_find prbuf_chk u_prbuf_chk (.*);
